// ----- hw/rtl/ilid_pkg.sv -----
// ilid_pkg: shared types and constants for the indexed list block.
// Holds the request/response beat structs, function and status codes.
// No dependencies.
package ilid_pkg;

  // default sizes
  localparam int CAPACITY_DEF   = 64;
  localparam int VALUE_BITS_DEF = 32;

  // function codes
  localparam logic [2:0] FN_READ     = 3'd0;
  localparam logic [2:0] FN_INS_HEAD = 3'd1;
  localparam logic [2:0] FN_INS_TAIL = 3'd2;
  localparam logic [2:0] FN_INS_AT   = 3'd3;
  localparam logic [2:0] FN_DELETE   = 3'd4;

  // status codes
  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  // request beat
  typedef struct packed {
    logic        [2:0]  func;
    logic signed [7:0]  position;
    logic signed [31:0] item_value;
  } req_t;

  // response beat
  typedef struct packed {
    logic signed [31:0] read_value;
    logic        [1:0]  status;
    logic        [6:0]  length_now;
  } rsp_t;

  // per-cell operation strobes, broadcast along the row
  typedef struct packed {
    logic ins;
    logic del;
    logic rd;
  } cell_op_t;

endpackage

// ----- hw/rtl/ilid_cell.sv -----
// ilid_cell: one storage slot of the list row.
// Shifts up from its left neighbour on insert, down from its right on delete.
// Depends on ilid_pkg.
module ilid_cell
  import ilid_pkg::*;
#(
  parameter int IDX        = 0,
  parameter int IDX_W      = 6,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  cell_op_t              op,
  input  logic [IDX_W-1:0]      tgt,
  input  logic [VALUE_BITS-1:0] new_val,
  input  logic [VALUE_BITS-1:0] left_val,
  input  logic [VALUE_BITS-1:0] right_val,
  output logic [VALUE_BITS-1:0] value,
  output logic [VALUE_BITS-1:0] rd_tap
);

  localparam logic [IDX_W-1:0] MY_IDX = IDX_W'(IDX);

  logic rd_sel;

  // slot contents: load, shift up, shift down or hold
  always_ff @(posedge clk) begin
    if (op.ins) begin
      if (MY_IDX == tgt) begin
        value <= new_val;
      end else if (MY_IDX > tgt) begin
        value <= left_val;
      end
    end else if (op.del && (MY_IDX >= tgt)) begin
      value <= right_val;
    end
  end

  // read select, one-hot across the row
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_sel <= 1'b0;
    end else begin
      rd_sel <= op.rd && (MY_IDX == tgt);
    end
  end

  assign rd_tap = rd_sel ? value : '0;

endmodule

// ----- hw/rtl/indexed_list_insert_delete.sv -----
// indexed_list_insert_delete: ordered list with read/insert/delete by position.
// Top level; builds a row of ilid_cell slots. Depends on ilid_pkg, ilid_cell.
//
//   channel   handshake          payload  notes
//   request   start, busy        req      taken when start && !busy
//   response  done (one cycle)   rsp      one beat per request, no back-pressure
//
// All slots shift in parallel at the accept edge, and the response beat
// follows on the next cycle.
// A new request may be taken in the same cycle as the previous response.
// Reset (rst, synchronous) empties the list; busy is high during reset and
// while its registered copy rst_q is still set. Slot contents are not cleared.
module indexed_list_insert_delete
  import ilid_pkg::*;
#(
  parameter int CAPACITY   = CAPACITY_DEF,
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  input  req_t req,
  output logic done,
  output rsp_t rsp
);

  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = ((CNT_W > 8) ? CNT_W : 8) + 1;
  localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      count_next;
  logic                  rst_q;
  logic                  accept;
  logic [1:0]            status;
  logic [1:0]            status_next;
  logic                  rd_ok;
  logic                  rd_ok_next;
  cell_op_t              op;
  logic [IDX_W-1:0]      tgt;
  logic [VALUE_BITS-1:0] new_val;
  logic                  pos_neg;
  logic [CMP_W-1:0]      pos_ext;
  logic [CMP_W-1:0]      cnt_ext;
  logic                  full;

  logic [VALUE_BITS-1:0] slot_val [CAPACITY];
  logic [VALUE_BITS-1:0] slot_tap [CAPACITY];
  logic signed [VALUE_BITS-1:0] rd_or;

  assign busy   = rst || rst_q;
  assign accept = start && !busy;

  // operand prep
  assign new_val = VALUE_BITS'(req.item_value);
  assign pos_neg = req.position[7];
  assign pos_ext = CMP_W'(req.position[6:0]);
  assign cnt_ext = CMP_W'(count);
  assign full    = (count == CAP_CNT);

  // request decode
  always_comb begin
    op          = '0;
    tgt         = '0;
    count_next  = count;
    status_next = ST_RANGE;
    rd_ok_next  = 1'b0;
    unique case (req.func) inside
      FN_READ: begin
        if (!pos_neg && (pos_ext < cnt_ext)) begin
          op.rd       = accept;
          tgt         = IDX_W'(pos_ext);
          rd_ok_next  = 1'b1;
          status_next = ST_DONE;
        end
      end
      FN_INS_HEAD, FN_INS_TAIL, FN_INS_AT: begin
        if (req.func == FN_INS_TAIL) begin
          tgt = IDX_W'(count);
        end else if (req.func == FN_INS_AT && !pos_neg) begin
          tgt = IDX_W'(pos_ext);
        end
        if (req.func == FN_INS_AT && !pos_neg && (pos_ext > cnt_ext)) begin
          status_next = ST_RANGE;
        end else if (full) begin
          status_next = ST_FULL;
        end else begin
          status_next = ST_DONE;
          op.ins      = accept;
          count_next  = count + CNT_W'(1);
        end
      end
      FN_DELETE: begin
        if (!pos_neg && (pos_ext < cnt_ext)) begin
          op.del      = accept;
          tgt         = IDX_W'(pos_ext);
          status_next = ST_DONE;
          count_next  = count - CNT_W'(1);
        end
      end
      default: begin
        status_next = ST_RANGE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      done  <= 1'b0;
      rst_q <= 1'b1;
    end else begin
      rst_q <= 1'b0;
      done  <= accept;
      if (accept) begin
        count <= count_next;
      end
    end
  end

  // response fields, held with the beat
  always_ff @(posedge clk) begin
    if (accept) begin
      status <= status_next;
      rd_ok  <= rd_ok_next;
    end
  end

  // row of slots
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [VALUE_BITS-1:0] left_v;
    logic [VALUE_BITS-1:0] right_v;
    if (i == 0) begin : g_first
      assign left_v = new_val;
    end else begin : g_mid_l
      assign left_v = slot_val[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right_v = slot_val[i];
    end else begin : g_mid_r
      assign right_v = slot_val[i+1];
    end
    ilid_cell #(
      .IDX        (i),
      .IDX_W      (IDX_W),
      .VALUE_BITS (VALUE_BITS)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .op        (op),
      .tgt       (tgt),
      .new_val   (new_val),
      .left_val  (left_v),
      .right_val (right_v),
      .value     (slot_val[i]),
      .rd_tap    (slot_tap[i])
    );
  end

  // gather the selected slot, at most one tap is live
  always_comb begin
    rd_or = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      rd_or = rd_or | slot_tap[k];
    end
  end

  // response beat
  assign rsp.read_value = rd_ok ? 32'(rd_or) : -32'sd1;
  assign rsp.status     = status;
  assign rsp.length_now = 7'(count);

endmodule

// ----- hw/rtl/ilid_checker.sv -----
// ilid_checker: port-level checks on the indexed list block.
// Bound to indexed_list_insert_delete. Depends on ilid_pkg.
module ilid_checker
  import ilid_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input req_t req,
  input logic done,
  input rsp_t rsp
);

  // every accepted request gives a beat on the next cycle
  a_beat_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("missing response beat");

  // no beat without a request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy))
    else $error("response beat without request");

  // refused requests return all ones (successful non-read requests are not checked)
  a_fail_value: assert property (@(posedge clk) disable iff (rst)
    (done && rsp.status != ST_DONE) |-> (rsp.read_value == -32'sd1))
    else $error("read_value not -1 on refused request");

  // status is one of the three codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> (rsp.status == ST_DONE || rsp.status == ST_RANGE ||
              rsp.status == ST_FULL))
    else $error("bad status code");

endmodule

bind indexed_list_insert_delete ilid_checker u_ilid_checker (.*);
